// File: hdl/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
// Used by the channel interfaces, the cell, the chain and the top level.
package dltq_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 3;
  localparam int DELTA_W   = 32;
  localparam int ID_SLOTS  = 1 << ID_W;
  localparam int MAX_OUT   = 8;
  localparam int OUT_CNT_W = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TICK
  } state_t;

  // Whole-chain commands issued by the controller
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_INSERT,
    CH_REMOVE,
    CH_MERGE,
    CH_HEAD_DEC
  } chain_op_t;

  // Per-cell operations decoded from a chain command
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_PREV_SUB,
    CELL_FROM_NEXT,
    CELL_FROM_NEXT_ADD,
    CELL_LOAD,
    CELL_SUB
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } cell_data_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ID_W-1:0]    arg_id;
    logic [DELTA_W-1:0] arg_delta;
  } cell_ctl_t;

endpackage

// File: hdl/dltq_if.sv
// Valid/ready channel interfaces for the timer queue: request items in,
// expiry results out. Depends on dltq_pkg for field widths.
interface dltq_req_if;
  logic                         valid;
  logic                         ready;
  logic [dltq_pkg::KIND_W-1:0]  kind;
  logic [dltq_pkg::ID_W-1:0]    timer_id;
  logic [dltq_pkg::DELTA_W-1:0] interval;
  logic                         periodic;

  modport source (output valid, kind, timer_id, interval, periodic, input ready);
  modport sink   (input valid, kind, timer_id, interval, periodic, output ready);
endinterface

interface dltq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [dltq_pkg::ID_W-1:0] expired_id;
  logic                      last;

  modport source (output valid, expired_id, last, input ready);
  modport sink   (input valid, expired_id, last, output ready);
endinterface

// File: hdl/delta_list_timer_queue.sv
// Delta-list timer queue. Running timers sit in a row of cells in deadline order, each
// holding its id and its delay past the entry ahead. A stop merges its delta into the entry
// behind it without leaving the idle state. A start walks the row one entry per cycle to find
// its place, then shifts the tail in one step. A tick takes due entries off the head, and
// each periodic expiry adds the same insertion walk, since a single walker serves the row.
// Expiries leave through a result register, so a tick stalls only when it is full.
// Depends on dltq_pkg, dltq_if, dltq_chain and dltq_cell.
module delta_list_timer_queue #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  dltq_req_if.sink   req,
  dltq_rsp_if.source rsp
);
  import dltq_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    p, p_next;
  logic [DELTA_W-1:0]  rem, rem_next;
  logic [ID_W-1:0]     ins_id, ins_id_next;
  logic                ins_from_tick, ins_from_tick_next;
  logic                elapsed, elapsed_next;
  logic [OUT_CNT_W-1:0] n_out, n_out_next;
  logic                pend_valid, pend_valid_next;
  logic [ID_W-1:0]     pend_id, pend_id_next;

  logic                out_valid;
  logic [ID_W-1:0]     out_id;
  logic                out_last;
  logic                push, push_last;

  logic [DELTA_W-1:0]  slot_interval [ID_SLOTS];
  logic                slot_periodic [ID_SLOTS];
  logic                slot_we;

  chain_op_t           ch_op;
  logic [CNT_W-1:0]    ch_pos;
  logic [ID_W-1:0]     ch_id;
  logic [DELTA_W-1:0]  ch_delta;
  logic                hit;
  logic [CNT_W-1:0]    hit_pos;
  logic [DELTA_W-1:0]  sel_delta;
  cell_data_t          head;

  logic                id_ok, out_free, due;
  logic [DELTA_W-1:0]  start_interval;

  dltq_chain #(.TIMER_SLOTS(TIMER_SLOTS)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .op        (ch_op),
    .pos       (ch_pos),
    .arg_id    (ch_id),
    .arg_delta (ch_delta),
    .find_id   (req.timer_id),
    .hit       (hit),
    .hit_pos   (hit_pos),
    .sel_delta (sel_delta),
    .head      (head)
  );

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.expired_id = out_id;
  assign rsp.last       = out_last;

  assign id_ok          = (32'(req.timer_id) < TIMER_SLOTS);
  assign start_interval = (req.interval == '0) ? DELTA_W'(1) : req.interval;
  assign out_free       = !out_valid || rsp.ready;
  assign due            = (count != '0) && (n_out < OUT_CNT_W'(MAX_OUT)) &&
                          (head.delta <= DELTA_W'(elapsed));

  always_comb begin
    state_next         = state;
    count_next         = count;
    p_next             = p;
    rem_next           = rem;
    ins_id_next        = ins_id;
    ins_from_tick_next = ins_from_tick;
    elapsed_next       = elapsed;
    n_out_next         = n_out;
    pend_valid_next    = pend_valid;
    pend_id_next       = pend_id;
    push               = 1'b0;
    push_last          = 1'b0;
    slot_we            = 1'b0;
    ch_op              = CH_HOLD;
    ch_pos             = p;
    ch_id              = ins_id;
    ch_delta           = rem;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          unique case (kind_t'(req.kind))
            KIND_START: begin
              if (id_ok && !hit) begin
                slot_we = 1'b1;
                if (count < CNT_W'(TIMER_SLOTS)) begin
                  rem_next           = start_interval;
                  ins_id_next        = req.timer_id;
                  p_next             = '0;
                  ins_from_tick_next = 1'b0;
                  state_next         = ST_INSERT;
                end
              end
            end
            KIND_STOP: begin
              if (id_ok && hit) begin
                ch_op      = CH_MERGE;
                ch_pos     = hit_pos;
                count_next = count - CNT_W'(1);
              end
            end
            KIND_TICK: begin
              elapsed_next    = 1'b1;
              n_out_next      = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_TICK;
            end
            default: ;
          endcase
        end
      end

      ST_INSERT: begin
        if (p < count && rem >= sel_delta) begin
          rem_next = rem - sel_delta;
          p_next   = p + CNT_W'(1);
        end else begin
          ch_op      = CH_INSERT;
          count_next = count + CNT_W'(1);
          state_next = ins_from_tick ? ST_TICK : ST_IDLE;
        end
      end

      ST_TICK: begin
        // the held expiry learns whether it is the last only once the next check is done
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            push      = 1'b1;
            push_last = !due;
          end
          if (due) begin
            ch_op           = CH_REMOVE;
            ch_pos          = '0;
            count_next      = count - CNT_W'(1);
            elapsed_next    = elapsed && (head.delta == '0);
            n_out_next      = n_out + OUT_CNT_W'(1);
            pend_valid_next = 1'b1;
            pend_id_next    = head.id;
            if (32'(head.id) < TIMER_SLOTS && slot_periodic[head.id]) begin
              rem_next           = slot_interval[head.id];
              ins_id_next        = head.id;
              p_next             = '0;
              ins_from_tick_next = 1'b1;
              state_next         = ST_INSERT;
            end
          end else begin
            if (count != '0 && elapsed && head.delta != '0) begin
              ch_op    = CH_HEAD_DEC;
              ch_delta = DELTA_W'(1);
            end
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p             <= p_next;
    rem           <= rem_next;
    ins_id        <= ins_id_next;
    ins_from_tick <= ins_from_tick_next;
    elapsed       <= elapsed_next;
    n_out         <= n_out_next;
    pend_id       <= pend_id_next;
    if (push) begin
      out_id   <= pend_id;
      out_last <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_interval[req.timer_id] <= start_interval;
      slot_periodic[req.timer_id] <= req.periodic;
    end
  end

endmodule

// File: hdl/dltq_cell.sv
// One list entry of the timer queue: valid flag, timer id and delta.
// Loads from either neighbour or from the broadcast argument. Uses dltq_pkg.
module dltq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  dltq_pkg::cell_ctl_t  ctl,
  input  dltq_pkg::cell_data_t prev,
  input  dltq_pkg::cell_data_t next,
  output dltq_pkg::cell_data_t q
);
  import dltq_pkg::*;

  logic               valid;
  logic [ID_W-1:0]    id;
  logic [DELTA_W-1:0] delta;
  cell_data_t         d_next;

  assign q = '{valid: valid, id: id, delta: delta};

  always_comb begin
    unique case (ctl.op)
      CELL_HOLD:          d_next = q;
      CELL_FROM_PREV:     d_next = prev;
      CELL_FROM_PREV_SUB: d_next = '{valid: prev.valid, id: prev.id,
                                     delta: prev.delta - ctl.arg_delta};
      CELL_FROM_NEXT:     d_next = next;
      CELL_FROM_NEXT_ADD: d_next = '{valid: next.valid, id: next.id,
                                     delta: next.delta + delta};
      CELL_LOAD:          d_next = '{valid: 1'b1, id: ctl.arg_id, delta: ctl.arg_delta};
      CELL_SUB:           d_next = '{valid: valid, id: id, delta: delta - ctl.arg_delta};
      default:            d_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= d_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    id    <= d_next.id;
    delta <= d_next.delta;
  end

endmodule

// File: hdl/dltq_chain.sv
// Row of dltq_cell entries holding the delta list in order, head at cell 0.
// Decodes chain commands per cell, finds a timer id and reads one delta.
// Uses dltq_pkg and dltq_cell.
module dltq_chain #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  dltq_pkg::chain_op_t                       op,
  input  logic [$clog2(TIMER_SLOTS+1)-1:0]          pos,
  input  logic [dltq_pkg::ID_W-1:0]                 arg_id,
  input  logic [dltq_pkg::DELTA_W-1:0]              arg_delta,
  input  logic [dltq_pkg::ID_W-1:0]                 find_id,
  output logic                                      hit,
  output logic [$clog2(TIMER_SLOTS+1)-1:0]          hit_pos,
  output logic [dltq_pkg::DELTA_W-1:0]              sel_delta,
  output dltq_pkg::cell_data_t                      head
);
  import dltq_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  cell_data_t c   [TIMER_SLOTS];
  cell_ctl_t  ctl [TIMER_SLOTS];

  assign head = c[0];

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    cell_data_t prev_d;
    cell_data_t next_d;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = c[i-1];
    end

    if (i == TIMER_SLOTS - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_next
      assign next_d = c[i+1];
    end

    always_comb begin
      ctl[i].arg_id    = arg_id;
      ctl[i].arg_delta = arg_delta;
      unique case (op)
        CH_HOLD:   ctl[i].op = CELL_HOLD;
        CH_INSERT: begin
          if (IDX < pos) begin
            ctl[i].op = CELL_HOLD;
          end else if (IDX == pos) begin
            ctl[i].op = CELL_LOAD;
          end else if (IDX == pos + CNT_W'(1)) begin
            ctl[i].op = CELL_FROM_PREV_SUB;
          end else begin
            ctl[i].op = CELL_FROM_PREV;
          end
        end
        CH_REMOVE: ctl[i].op = (IDX < pos) ? CELL_HOLD : CELL_FROM_NEXT;
        CH_MERGE: begin
          if (IDX < pos) begin
            ctl[i].op = CELL_HOLD;
          end else if (IDX == pos) begin
            ctl[i].op = CELL_FROM_NEXT_ADD;
          end else begin
            ctl[i].op = CELL_FROM_NEXT;
          end
        end
        CH_HEAD_DEC: ctl[i].op = (i == 0) ? CELL_SUB : CELL_HOLD;
        default:     ctl[i].op = CELL_HOLD;
      endcase
    end

    dltq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[i]),
      .prev (prev_d),
      .next (next_d),
      .q    (c[i])
    );
  end

  // ids in the list are distinct, so the first match is the only one
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (!hit && c[i].valid && c[i].id == find_id) begin
        hit     = 1'b1;
        hit_pos = CNT_W'(i);
      end
    end
  end

  always_comb begin
    sel_delta = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (pos == CNT_W'(i)) begin
        sel_delta = c[i].delta;
      end
    end
  end

endmodule
